### sv/ehp_pkg.sv
// ----------------------------------------------------------------------------
// ECG high-pass package
// Shared widths, reset values, register indexes, lead-off masks and the
// configuration bundle of the ECG high-pass block.
// ----------------------------------------------------------------------------
package ehp_pkg;

    // Default values of the top level parameters.
    localparam int LEAD_COUNT_DEF    = 8;
    localparam int SAMPLE_BITS_DEF   = 24;
    localparam int FRACTION_BITS_DEF = 16;

    // Fixed frame layout.
    localparam int MAX_LEADS   = 8;
    localparam int OUT_W       = 32;
    localparam int OUT_DATA_W  = MAX_LEADS * OUT_W;
    localparam int LEAD_OFF_W  = 9;
    localparam int REQ_W       = 8;
    localparam int USER_BITS   = LEAD_OFF_W + 1 + 1 + REQ_W;
    localparam int USER_W      = ((USER_BITS + 7) / 8) * 8;

    // Field offsets inside the input tuser.
    localparam int USER_OFF_LSB    = 0;
    localparam int USER_OFFSET_BIT = LEAD_OFF_W;
    localparam int USER_CALIB_BIT  = LEAD_OFF_W + 1;
    localparam int USER_REQ_LSB    = LEAD_OFF_W + 2;

    // Coefficient and counter formats.
    localparam int COEFF_W    = 16;
    localparam int COEFF_FRAC = 16;
    localparam int COUNT_W    = 9;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_HP_COEFF = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SETTLE   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RESTART  = 2'd2;

    // Register reset values.
    localparam logic [COEFF_W-1:0] HP_COEFF_RESET = 16'd65496;
    localparam logic [COUNT_W-1:0] SETTLE_RESET   = 9'd500;
    localparam logic [COUNT_W-1:0] RESTART_RESET  = 9'd12;

    // Electrodes that feed each lead: lead I uses RA and LA, lead II uses
    // RA and LL, each chest lead uses its own electrode plus RA, LA and LL.
    localparam logic [LEAD_OFF_W-1:0] LEAD_OFF_MASK [MAX_LEADS] = '{
        9'h003, 9'h005, 9'h00F, 9'h017, 9'h027, 9'h047, 9'h087, 9'h107
    };

    // Register values as seen by every lane.
    typedef struct packed {
        logic [COEFF_W-1:0] hp_coeff;
        logic [COUNT_W-1:0] settle_samples;
        logic [COUNT_W-1:0] restart_samples;
    } ehp_cfg_t;

endpackage

### sv/ehp_cfg.sv
// ----------------------------------------------------------------------------
// ECG high-pass configuration registers
// Holds the feedback coefficient and the two settling counts, written over
// a valid/ready channel that is always ready.
// ----------------------------------------------------------------------------
module ehp_cfg
    import ehp_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output ehp_cfg_t               cfg
);

    ehp_cfg_t cfg_reg;
    ehp_cfg_t cfg_next;

    // A write request is taken in every cycle.
    assign cfg_ready = 1'b1;

    // Decode the register index; unknown indexes leave everything alone.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_HP_COEFF: cfg_next.hp_coeff        = cfg_data[COEFF_W-1:0];
                REG_SETTLE:   cfg_next.settle_samples  = cfg_data[COUNT_W-1:0];
                REG_RESTART:  cfg_next.restart_samples = cfg_data[COUNT_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.hp_coeff        <= HP_COEFF_RESET;
            cfg_reg.settle_samples  <= SETTLE_RESET;
            cfg_reg.restart_samples <= RESTART_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### sv/ehp_lane.sv
// ----------------------------------------------------------------------------
// ECG high-pass lane
// One lead: DC-blocking filter y = (x - x_prev) * 2^F + floor(c * y_prev),
// lead-off muting, settling countdown and offset-triggered restart.
// ----------------------------------------------------------------------------
module ehp_lane
    import ehp_pkg::*;
#(
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          upd_en,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          connected,
    input  logic                          offset_step,
    input  logic                          reset_request,
    input  ehp_cfg_t                      cfg,
    output logic [OUT_W-1:0]              result
);

    localparam int Y_BITS = OUT_W + FRACTION_BITS;
    localparam int PROD_W = Y_BITS + COEFF_W + 1;
    localparam int STEP_W = SAMPLE_BITS + 1 + FRACTION_BITS;
    localparam int SUM_W  = Y_BITS + 2;

    // Lane state.
    logic [COUNT_W-1:0]            count_reg,   count_next;
    logic signed [SAMPLE_BITS-1:0] xprev_reg,   xprev_next;
    logic signed [Y_BITS-1:0]      yprev_reg,   yprev_next;
    logic                          pending_reg, pending_next;

    // Datapath signals.
    logic                     pending_mid;
    logic                     take_restart;
    logic [COUNT_W-1:0]       count_mid;
    logic signed [PROD_W-1:0] prod;
    logic signed [Y_BITS:0]   scaled;
    logic signed [SAMPLE_BITS:0] diff;
    logic signed [STEP_W-1:0] step;
    logic signed [SUM_W-1:0]  sum;
    logic                     overflow;
    logic signed [Y_BITS-1:0] y_sat;
    logic                     round_up;
    logic [OUT_W-1:0]         y_trunc;

    // Pending reset and the shortened restart on an offset step.
    assign pending_mid  = pending_reg | reset_request;
    assign take_restart = offset_step && pending_mid
                          && (count_reg < cfg.restart_samples);
    assign count_mid    = take_restart ? cfg.restart_samples : count_reg;

    // Feedback term, floored by the arithmetic shift.
    assign prod   = yprev_reg * $signed({1'b0, cfg.hp_coeff});
    assign scaled = prod[PROD_W-1:COEFF_FRAC];

    // Input difference scaled to the output fraction.
    assign diff = {sample[SAMPLE_BITS-1], sample} - {xprev_reg[SAMPLE_BITS-1], xprev_reg};
    assign step = {diff, {FRACTION_BITS{1'b0}}};

    assign sum = {{(SUM_W - STEP_W){step[STEP_W-1]}}, step}
               + {{(SUM_W - Y_BITS - 1){scaled[Y_BITS]}}, scaled};

    // Saturate to the stored width when the top bits disagree.
    assign overflow = (sum[SUM_W-1:Y_BITS-1] != {(SUM_W - Y_BITS + 1){1'b0}})
                   && (sum[SUM_W-1:Y_BITS-1] != {(SUM_W - Y_BITS + 1){1'b1}});

    always_comb begin
        if (overflow) begin
            y_sat = sum[SUM_W-1] ? {1'b1, {(Y_BITS - 1){1'b0}}}
                                 : {1'b0, {(Y_BITS - 1){1'b1}}};
        end else begin
            y_sat = sum[Y_BITS-1:0];
        end
    end

    // Drop the fraction, rounding toward zero for negative values.
    assign round_up = y_sat[Y_BITS-1] && (y_sat[FRACTION_BITS-1:0] != '0);
    assign y_trunc  = y_sat[Y_BITS-1:FRACTION_BITS] + {{(OUT_W - 1){1'b0}}, round_up};

    // Per-frame state update and lane output.
    always_comb begin
        count_next   = count_mid;
        xprev_next   = xprev_reg;
        yprev_next   = yprev_reg;
        pending_next = take_restart ? 1'b0 : pending_mid;
        result       = '0;
        if (connected) begin
            if (count_mid != '0) begin
                count_next = count_mid - 1'b1;
                // Last settling frame reseeds the filter.
                if (count_mid == {{(COUNT_W - 1){1'b0}}, 1'b1}) begin
                    xprev_next = sample;
                    yprev_next = '0;
                end
            end else begin
                xprev_next = sample;
                yprev_next = y_sat;
                result     = y_trunc;
            end
        end else begin
            count_next = cfg.settle_samples;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= SETTLE_RESET;
            xprev_reg   <= '0;
            yprev_reg   <= '0;
            pending_reg <= 1'b0;
        end else if (upd_en) begin
            count_reg   <= count_next;
            xprev_reg   <= xprev_next;
            yprev_reg   <= yprev_next;
            pending_reg <= pending_next;
        end
    end

endmodule

### sv/ecg_highpass_with_lead_off_settling.sv
// ----------------------------------------------------------------------------
// ECG high-pass with lead-off settling
// Eight-lead DC-blocking high-pass filter with electrode-off muting,
// settling countdown and offset-triggered restart, one frame per request.
// ----------------------------------------------------------------------------
// Path: an accepted request reaches m_tvalid through the input register, then the result register.
// Throughput: one frame per cycle unless m_tready stalls the result; each lead has its own
// multiplier and the filter feedback is combinational from the input register.
// Reset: aresetn is synchronous and active low; it empties both stages,
// restores the register defaults and reloads every settling counter to 500.
// ----------------------------------------------------------------------------
module ecg_highpass_with_lead_off_settling
    import ehp_pkg::*;
#(
    parameter int LEAD_COUNT    = LEAD_COUNT_DEF,
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Input frame
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // sample_lead0 .. sample_lead7, SAMPLE_BITS each, lead0 lowest
    input  logic [MAX_LEADS*SAMPLE_BITS-1:0]   s_tdata,
    // electrode_off[8:0], offset_step[9], calibration[10],
    // reset_request[18:11], upper bits zero
    input  logic [USER_W-1:0]                  s_tuser,
    // Result frame
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // out_lead0 .. out_lead7, 32 bits each, lead0 lowest
    output logic [OUT_DATA_W-1:0]              m_tdata,
    // Configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [CFG_INDEX_W-1:0]             cfg_index,
    input  logic [CFG_DATA_W-1:0]              cfg_data
);

    localparam int DATA_W = MAX_LEADS * SAMPLE_BITS;

    ehp_cfg_t cfg;

    logic                  in_valid_reg;
    logic [DATA_W-1:0]     in_data_reg;
    logic [USER_W-1:0]     in_user_reg;
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;
    logic                  advance;

    logic [LEAD_OFF_W-1:0] electrode_off;
    logic                  offset_step;
    logic                  calibration;
    logic [REQ_W-1:0]      reset_request;

    // Configuration registers.
    ehp_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Handshake: the held frame moves on when the result register frees up.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
            in_user_reg <= s_tuser;
        end
    end

    // Unpack the frame flags.
    assign electrode_off = in_user_reg[USER_OFF_LSB +: LEAD_OFF_W];
    assign offset_step   = in_user_reg[USER_OFFSET_BIT];
    assign calibration   = in_user_reg[USER_CALIB_BIT];
    assign reset_request = in_user_reg[USER_REQ_LSB +: REQ_W];

    // One lane per active lead; the remaining leads read zero.
    for (genvar g = 0; g < MAX_LEADS; g++) begin : g_lead
        if (g < LEAD_COUNT) begin : g_active
            logic connected;

            assign connected = ((electrode_off & LEAD_OFF_MASK[g]) == '0) || calibration;

            ehp_lane #(
                .SAMPLE_BITS   (SAMPLE_BITS),
                .FRACTION_BITS (FRACTION_BITS)
            ) u_lane (
                .aclk          (aclk),
                .aresetn       (aresetn),
                .upd_en        (advance),
                .sample        (in_data_reg[g*SAMPLE_BITS +: SAMPLE_BITS]),
                .connected     (connected),
                .offset_step   (offset_step),
                .reset_request (reset_request[g]),
                .cfg           (cfg),
                .result        (out_data_next[g*OUT_W +: OUT_W])
            );
        end else begin : g_unused
            assign out_data_next[g*OUT_W +: OUT_W] = '0;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

### sv/ehp_checker.sv
// ----------------------------------------------------------------------------
// ECG high-pass port checker
// Watches the top level ports for back-pressure, reset and hold behavior.
// ----------------------------------------------------------------------------
module ehp_checker
    import ehp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tready,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata
);

    // A stalled result request keeps its data.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result request changed while stalled");

    // Reset leaves both stages empty and the input open.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
    else $error("pipeline not empty after reset");

    // The input only closes when both stages are full and the output stalls.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without output back-pressure");

endmodule

bind ecg_highpass_with_lead_off_settling ehp_checker u_ehp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### test/ehp_check_pkg.sv
// ----------------------------------------------------------------------------
// ECG high-pass checker package
// Holds the scoreboard of the lead filter testbench. It tracks the register
// values and the state of every lead, works out the frame that each accepted
// request must produce, and compares the result frames against that queue.
// ----------------------------------------------------------------------------
package ehp_check_pkg;
    import ehp_pkg::*;

    localparam int SAMPLE_W  = SAMPLE_BITS_DEF;
    localparam int FRAC_W    = FRACTION_BITS_DEF;
    localparam int IN_DATA_W = MAX_LEADS * SAMPLE_W;

    // The filter state keeps 32 integer bits and FRAC_W fraction bits.
    localparam longint Y_MAX   = (longint'(1) <<< (OUT_W + FRAC_W - 1)) - 1;
    localparam longint Y_MIN   = -Y_MAX - 1;
    localparam longint OUT_MAX = 64'sd2147483647;
    localparam longint OUT_MIN = -64'sd2147483648;

    class lead_filter_scoreboard;
        logic [COEFF_W-1:0]    hp_coeff;
        logic [COUNT_W-1:0]    settle_len;
        logic [COUNT_W-1:0]    restart_len;
        logic [COUNT_W-1:0]    settle_cnt [MAX_LEADS];
        longint                last_x [MAX_LEADS];
        longint                last_y [MAX_LEADS];
        bit                    pending [MAX_LEADS];
        logic [OUT_DATA_W-1:0] want_frames [$];
        int                    mismatches;
        int                    checked;

        function new();
            int lead;
            hp_coeff    = HP_COEFF_RESET;
            settle_len  = SETTLE_RESET;
            restart_len = RESTART_RESET;
            for (lead = 0; lead < MAX_LEADS; lead++) begin
                settle_cnt[lead] = SETTLE_RESET;
                last_x[lead]     = 0;
                last_y[lead]     = 0;
                pending[lead]    = 1'b0;
            end
            mismatches = 0;
            checked    = 0;
        endfunction

        // Only the low bits of a write reach a register; unused indexes do nothing.
        function void apply_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                REG_HP_COEFF: hp_coeff    = data[COEFF_W-1:0];
                REG_SETTLE:   settle_len  = data[COUNT_W-1:0];
                REG_RESTART:  restart_len = data[COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        // Advances every lead by one frame and queues the frame it must output.
        function void filter_frame(logic [IN_DATA_W-1:0] data, logic [USER_W-1:0] user);
            logic [LEAD_OFF_W-1:0]      off;
            logic [REQ_W-1:0]           req;
            logic signed [SAMPLE_W-1:0] sample;
            logic [OUT_DATA_W-1:0]      frame;
            longint                     x;
            longint                     y;
            longint                     coeff;
            longint                     mag;
            int                         lead;
            off   = user[USER_OFF_LSB +: LEAD_OFF_W];
            req   = user[USER_REQ_LSB +: REQ_W];
            coeff = hp_coeff;
            frame = '0;

            // Requests latch first, then an offset step may shorten settling.
            for (lead = 0; lead < MAX_LEADS; lead++) begin
                if (req[lead]) begin
                    pending[lead] = 1'b1;
                end
            end
            if (user[USER_OFFSET_BIT]) begin
                for (lead = 0; lead < MAX_LEADS; lead++) begin
                    if (pending[lead] && settle_cnt[lead] < restart_len) begin
                        settle_cnt[lead] = restart_len;
                        pending[lead]    = 1'b0;
                    end
                end
            end

            for (lead = 0; lead < MAX_LEADS; lead++) begin
                sample = data[lead*SAMPLE_W +: SAMPLE_W];
                x      = sample;
                if ((off & LEAD_OFF_MASK[lead]) == '0 || user[USER_CALIB_BIT]) begin
                    if (settle_cnt[lead] != '0) begin
                        // Still settling; the last count reseeds the filter.
                        settle_cnt[lead] = settle_cnt[lead] - 1'b1;
                        if (settle_cnt[lead] == '0) begin
                            last_x[lead] = x;
                            last_y[lead] = 0;
                        end
                    end else begin
                        // Floored feedback product, then saturation of the state.
                        y = (x - last_x[lead]) * (longint'(1) <<< FRAC_W)
                            + ((last_y[lead] * coeff) >>> COEFF_FRAC);
                        if (y > Y_MAX) y = Y_MAX;
                        if (y < Y_MIN) y = Y_MIN;
                        last_x[lead] = x;
                        last_y[lead] = y;
                        // Output drops the fraction toward zero and clamps to 32 bits.
                        mag = (y < 0) ? -y : y;
                        mag = mag >> FRAC_W;
                        mag = (y < 0) ? -mag : mag;
                        if (mag > OUT_MAX) mag = OUT_MAX;
                        if (mag < OUT_MIN) mag = OUT_MIN;
                        frame[lead*OUT_W +: OUT_W] = mag[OUT_W-1:0];
                    end
                end else begin
                    settle_cnt[lead] = settle_len;
                end
            end
            want_frames.push_back(frame);
        endfunction

        // Compares one result frame lead by lead with the oldest expectation.
        function void check_frame(logic [OUT_DATA_W-1:0] got);
            logic [OUT_DATA_W-1:0] want;
            int                    lead;
            checked++;
            if (want_frames.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Result %0d arrived with no request waiting", checked);
                end
                return;
            end
            want = want_frames.pop_front();
            for (lead = 0; lead < MAX_LEADS; lead++) begin
                if (got[lead*OUT_W +: OUT_W] !== want[lead*OUT_W +: OUT_W]) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Result %0d lead %0d: expected %0d, got %0d", checked, lead,
                                 $signed(want[lead*OUT_W +: OUT_W]),
                                 $signed(got[lead*OUT_W +: OUT_W]));
                    end
                end
            end
        endfunction
    endclass

endpackage

### test/tb.sv
// ----------------------------------------------------------------------------
// ECG high-pass block testbench
// Drives eight-lead frames through the high-pass block with random gaps on
// both sides, a long receiver hold-off and several register settings, and
// checks every result frame against a scoreboard that tracks each lead.
// ----------------------------------------------------------------------------
module tb;
    import ehp_pkg::*;
    import ehp_check_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASES       = 8;
    localparam int PHASE_FRAMES = 125;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata;
    logic [USER_W-1:0]      s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    lead_filter_scoreboard sb;
    bit  no_gaps;
    int  hold_left;
    int  stall_cycles;
    bit  moved;
    int  frames_in;
    int  reg_writes;

    ecg_highpass_with_lead_off_settling DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Record every handshake at the rising edge and watch for a hung block.
    always @(posedge aclk) begin
        if (aresetn) begin
            moved = 1'b0;
            if (cfg_valid && cfg_ready) begin
                sb.apply_reg(cfg_index, cfg_data);
                moved = 1'b1;
            end
            if (s_tvalid && s_tready) begin
                sb.filter_frame(s_tdata, s_tuser);
                frames_in++;
                moved = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                sb.check_frame(m_tdata);
                moved = 1'b1;
            end
            stall_cycles = moved ? 0 : stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
                $display("[ecg_highpass_with_lead_off_settling] ERROR");
                $finish;
            end
        end
    end

    // Result side: random back-pressure, a gap-free stretch, and a long hold-off.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (no_gaps) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= 36);
            end
        end
    end

    function automatic logic [USER_W-1:0] make_user(logic [LEAD_OFF_W-1:0] off, bit offset,
                                                    bit calib, logic [REQ_W-1:0] req);
        logic [USER_W-1:0] u;
        u = '0;
        u[USER_OFF_LSB +: LEAD_OFF_W] = off;
        u[USER_OFFSET_BIT]            = offset;
        u[USER_CALIB_BIT]             = calib;
        u[USER_REQ_LSB +: REQ_W]      = req;
        return u;
    endfunction

    function automatic logic [IN_DATA_W-1:0] same_samples(logic [SAMPLE_W-1:0] value);
        return {MAX_LEADS{value}};
    endfunction

    // Mix of full-range noise, rail values and a small ECG-like signal.
    function automatic logic [IN_DATA_W-1:0] random_samples();
        logic [IN_DATA_W-1:0] d;
        int                   lead;
        for (lead = 0; lead < MAX_LEADS; lead++) begin
            case ($urandom_range(9))
                0, 1, 2: d[lead*SAMPLE_W +: SAMPLE_W] = SAMPLE_W'($urandom);
                3: begin
                    case ($urandom_range(3))
                        0: d[lead*SAMPLE_W +: SAMPLE_W] = 24'h7FFFFF;
                        1: d[lead*SAMPLE_W +: SAMPLE_W] = 24'h800000;
                        2: d[lead*SAMPLE_W +: SAMPLE_W] = 24'h000000;
                        default: d[lead*SAMPLE_W +: SAMPLE_W] = 24'hFFFFFF;
                    endcase
                end
                default: begin
                    d[lead*SAMPLE_W +: SAMPLE_W] = 24'($urandom_range(4000)) - 24'd2000;
                end
            endcase
        end
        return d;
    endfunction

    // Mostly electrodes on so the filters run; occasional lead-off, offset and requests.
    function automatic logic [USER_W-1:0] random_user();
        logic [LEAD_OFF_W-1:0] off;
        int                    r;
        r = $urandom_range(99);
        if (r < 75) off = '0;
        else if (r < 88) off = 9'd1 << $urandom_range(LEAD_OFF_W - 1);
        else off = 9'($urandom);
        return make_user(off, $urandom_range(99) < 10, $urandom_range(99) < 6,
                         ($urandom_range(99) < 12) ? 8'($urandom) : 8'd0);
    endfunction

    task automatic send_frame(input logic [IN_DATA_W-1:0] data, input logic [USER_W-1:0] user);
        @(negedge aclk);
        while (!no_gaps && $urandom_range(99) < 36) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= user;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        reg_writes++;
    endtask

    // Stop offering requests and wait until every result frame is back.
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.want_frames.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        int                    phase;
        int                    n;
        int                    k;
        logic [CFG_DATA_W-1:0] coeff_val;
        logic [CFG_DATA_W-1:0] settle_val;
        logic [CFG_DATA_W-1:0] restart_val;

        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        no_gaps      = 1'b0;
        hold_left    = 0;
        stall_cycles = 0;
        frames_in    = 0;
        reg_writes   = 0;
        sb = new();

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Register defaults: every lead is still settling after reset.
        send_frame(same_samples(24'h123456), make_user('0, 1'b0, 1'b0, '0));
        send_frame(same_samples(24'h654321), make_user('0, 1'b0, 1'b0, '0));
        drain();

        // Short settling so the directed frames reach the running filter.
        write_reg(REG_HP_COEFF, 16'hFFFF);
        write_reg(REG_SETTLE, 16'd2);
        write_reg(REG_RESTART, 16'd5);

        // All electrodes off reloads the counters, then settle and reseed at the rail.
        send_frame(same_samples(24'h000100), make_user('1, 1'b0, 1'b0, '0));
        send_frame(same_samples(24'h7FFFFF), make_user('0, 1'b0, 1'b0, '0));
        send_frame(same_samples(24'h7FFFFF), make_user('0, 1'b0, 1'b0, '0));
        // Full-scale steps in both directions.
        send_frame(same_samples(24'h800000), make_user('0, 1'b0, 1'b0, '0));
        send_frame(same_samples(24'h7FFFFF), make_user('0, 1'b0, 1'b0, '0));
        send_frame(same_samples(24'h000000), make_user('0, 1'b0, 1'b0, '0));
        // Each electrode alone mutes its own set of leads.
        for (k = 0; k < LEAD_OFF_W; k++) begin
            send_frame(random_samples(), make_user(9'd1 << k, 1'b0, 1'b0, '0));
        end
        // Calibration overrides the off flags; requests latch without an offset.
        send_frame(random_samples(), make_user('1, 1'b0, 1'b1, 8'hFF));
        // Offset step with every lead pending, then one with nothing pending.
        send_frame(random_samples(), make_user('0, 1'b1, 1'b0, '0));
        send_frame(random_samples(), make_user('0, 1'b1, 1'b0, '0));
        // Request in the same frame as the offset, with chest electrodes off.
        send_frame(random_samples(), make_user('0, 1'b0, 1'b0, 8'hA5));
        send_frame(random_samples(), make_user(9'h1F8, 1'b1, 1'b0, 8'h5A));
        drain();

        // Random phases, each under its own register setting.
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    coeff_val   = 16'hFFFF;
                    settle_val  = 16'd1;
                    restart_val = 16'd511;
                end
                1: begin
                    // Zero counts: no reseed on return and offsets never restart.
                    coeff_val   = 16'd0;
                    settle_val  = 16'd0;
                    restart_val = 16'd0;
                end
                2: begin
                    coeff_val   = HP_COEFF_RESET;
                    settle_val  = 16'd511;
                    restart_val = 16'd1;
                end
                default: begin
                    coeff_val   = 16'($urandom);
                    settle_val  = {7'($urandom), 9'($urandom_range(12))};
                    restart_val = {7'($urandom), 9'($urandom_range(24))};
                end
            endcase
            write_reg(REG_HP_COEFF, coeff_val);
            write_reg(REG_SETTLE, settle_val);
            write_reg(REG_RESTART, restart_val);
            if (phase == 3) begin
                write_reg(REG_UNUSED, 16'($urandom));
            end
            no_gaps = (phase == 6);
            for (n = 0; n < PHASE_FRAMES; n++) begin
                send_frame(random_samples(), random_user());
                // Receiver stops for a long while as requests keep coming.
                if (phase == 5 && n == 40) begin
                    hold_left = HOLD_CYCLES;
                end
            end
            drain();
        end

        sb.mismatches += sb.want_frames.size();
        $display("Sent %0d frames under %0d register settings with %0d register writes.",
                 frames_in, PHASES + 2, reg_writes);
        $display("Checked %0d result frames, covering lead-off, settling, restarts and stalls.",
                 sb.checked);
        if (sb.mismatches == 0) begin
            $display("[ecg_highpass_with_lead_off_settling] OK");
        end else begin
            $display("Mismatches: %0d", sb.mismatches);
            $display("[ecg_highpass_with_lead_off_settling] ERROR");
        end
        $finish;
    end

endmodule
